// File: rtl/hbrd_pkg.sv
// shared types, register indexes and the weapon duty table for the h-bridge reversal core
package hbrd_pkg;

    typedef enum logic [1:0] {
        ACT_DRIVE_RIGHT = 2'd0,
        ACT_DRIVE_LEFT  = 2'd1,
        ACT_WEAPON_UP   = 2'd2,
        ACT_WEAPON_DOWN = 2'd3
    } action_t;

    typedef enum logic {
        REG_STICK_DEADBAND    = 1'b0,
        REG_REVERSAL_DELAY_MS = 1'b1
    } reg_index_t;

    localparam logic [6:0]  DEADBAND_RESET = 7'd10;
    localparam logic [15:0] DELAY_RESET    = 16'd500;
    localparam logic [3:0]  LEVEL_MAX      = 4'd9;

    // duty = 255 / (11 - level), zero at level zero
    function automatic logic [7:0] weapon_duty_of(input logic [3:0] level);
        logic [7:0] duty;
        begin
            unique case (level)
                4'd0:    duty = 8'd0;
                4'd1:    duty = 8'd25;
                4'd2:    duty = 8'd28;
                4'd3:    duty = 8'd31;
                4'd4:    duty = 8'd36;
                4'd5:    duty = 8'd42;
                4'd6:    duty = 8'd51;
                4'd7:    duty = 8'd63;
                4'd8:    duty = 8'd85;
                default: duty = 8'd127;
            endcase
            return duty;
        end
    endfunction

endpackage

// File: rtl/dual_hbridge_reversal_delay_core.sv
// two-side h-bridge drive with reversal delay and deadband, plus weapon level control
// Each request (action, stick_value, now_ms) is taken into an input register and
// is evaluated there against the drive and weapon state; the result register
// then shows every duty, the weapon level and both waiting flags after that request.
// One request is accepted per cycle while in_stall is low, and a stalled result
// holds both stages (in_stall rises only when the input register is full and the
// result register cannot be taken). The per-request path is two deadband compares, one
// 32-bit wrapping add and compare for the delay expiry, and a ten-entry table lookup
// for the weapon duty. Registers are to be written over the APB port only while no
// request is in flight, which the block does not enforce: 0x0 stick_deadband (7 bits,
// reset 10), 0x4 reversal_delay_ms (16 bits, reset 500). A delay starting at time
// zero is treated as idle, and the request that ends a delay writes no drive duty.
module dual_hbridge_reversal_delay_core
    import hbrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic signed [7:0] stick_value,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  right_forward_duty,
    output logic [7:0]  right_reverse_duty,
    output logic [7:0]  left_forward_duty,
    output logic [7:0]  left_reverse_duty,
    output logic [7:0]  weapon_duty,
    output logic [3:0]  weapon_level,
    output logic        right_waiting,
    output logic        left_waiting
);

    // configuration
    logic [6:0]  deadband_reg;
    logic [15:0] delay_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= DEADBAND_RESET;
            delay_reg    <= DELAY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_STICK_DEADBAND:    deadband_reg <= pwdata[6:0];
                REG_REVERSAL_DELAY_MS: delay_reg    <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[2]))
            REG_STICK_DEADBAND:    prdata = {25'd0, deadband_reg};
            REG_REVERSAL_DELAY_MS: prdata = {16'd0, delay_reg};
        endcase
    end

    // pipeline control
    logic advance;
    logic s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [7:0]  s1_stick_reg;
    logic [31:0] s1_now_reg;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_stick_reg  <= stick_value;
            s1_now_reg    <= now_ms;
        end
    end

    // state
    logic        right_fwd_reg, left_fwd_reg;
    logic [31:0] right_start_reg, left_start_reg;
    logic [3:0]  level_reg;
    logic [7:0]  rf_duty_reg, rr_duty_reg, lf_duty_reg, lr_duty_reg, w_duty_reg;
    logic        out_valid_reg;

    // evaluation of the selected side
    logic        side_left;
    logic        cur_fwd;
    logic [31:0] cur_start;
    logic [7:0]  cur_fduty, cur_rduty;
    logic [8:0]  dc9, db9, mag9;
    logic        go_fwd, go_rev;
    logic [7:0]  drive_duty;
    logic [31:0] expire_at;
    logic        expired;
    logic        side_fwd_next;
    logic [31:0] side_start_next;
    logic [7:0]  side_fduty_next, side_rduty_next;
    logic [3:0]  level_up, level_down;

    assign side_left = (action_t'(s1_action_reg) == ACT_DRIVE_LEFT);
    assign cur_fwd   = side_left ? left_fwd_reg    : right_fwd_reg;
    assign cur_start = side_left ? left_start_reg  : right_start_reg;
    assign cur_fduty = side_left ? lf_duty_reg     : rf_duty_reg;
    assign cur_rduty = side_left ? lr_duty_reg     : rr_duty_reg;

    assign dc9    = {s1_stick_reg[7], s1_stick_reg};
    assign db9    = {2'b00, deadband_reg};
    assign go_rev = $signed(dc9) < $signed(-db9);
    assign go_fwd = $signed(dc9) > $signed(db9);
    assign mag9   = go_fwd ? dc9 : -dc9;
    // twice the magnitude, saturated
    assign drive_duty = (mag9 > 9'd127) ? 8'hFF : {mag9[6:0], 1'b0};

    assign expire_at = cur_start + {16'd0, delay_reg};
    assign expired   = s1_now_reg > expire_at;

    always_comb
    begin
        side_fwd_next   = cur_fwd;
        side_start_next = cur_start;
        side_fduty_next = cur_fduty;
        side_rduty_next = cur_rduty;
        if (!go_fwd && !go_rev)
        begin
            side_fduty_next = 8'd0;
            side_rduty_next = 8'd0;
        end
        else
        begin
            if (go_fwd)
                side_rduty_next = 8'd0;
            else
                side_fduty_next = 8'd0;
            priority if (cur_fwd != go_fwd)
            begin
                side_start_next = s1_now_reg;
                side_fwd_next   = go_fwd;
            end
            else if (cur_start != 32'd0)
            begin
                if (expired)
                    side_start_next = 32'd0;
            end
            else if (go_fwd)
            begin
                side_fduty_next = drive_duty;
            end
            else
            begin
                side_rduty_next = drive_duty;
            end
        end
    end

    assign level_up   = (level_reg < LEVEL_MAX) ? level_reg + 4'd1 : LEVEL_MAX;
    assign level_down = (level_reg > LEVEL_MAX) ? LEVEL_MAX - 4'd1
                      : (level_reg > 4'd0)      ? level_reg - 4'd1 : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            right_fwd_reg   <= 1'b0;
            left_fwd_reg    <= 1'b0;
            right_start_reg <= 32'd0;
            left_start_reg  <= 32'd0;
            level_reg       <= 4'd0;
            rf_duty_reg     <= 8'd0;
            rr_duty_reg     <= 8'd0;
            lf_duty_reg     <= 8'd0;
            lr_duty_reg     <= 8'd0;
            w_duty_reg      <= 8'd0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                unique case (action_t'(s1_action_reg))
                    ACT_DRIVE_RIGHT:
                    begin
                        right_fwd_reg   <= side_fwd_next;
                        right_start_reg <= side_start_next;
                        rf_duty_reg     <= side_fduty_next;
                        rr_duty_reg     <= side_rduty_next;
                    end
                    ACT_DRIVE_LEFT:
                    begin
                        left_fwd_reg    <= side_fwd_next;
                        left_start_reg  <= side_start_next;
                        lf_duty_reg     <= side_fduty_next;
                        lr_duty_reg     <= side_rduty_next;
                    end
                    ACT_WEAPON_UP:
                    begin
                        level_reg  <= level_up;
                        w_duty_reg <= weapon_duty_of(level_up);
                    end
                    ACT_WEAPON_DOWN:
                    begin
                        level_reg  <= level_down;
                        w_duty_reg <= weapon_duty_of(level_down);
                    end
                endcase
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign right_forward_duty = rf_duty_reg;
    assign right_reverse_duty = rr_duty_reg;
    assign left_forward_duty  = lf_duty_reg;
    assign left_reverse_duty  = lr_duty_reg;
    assign weapon_duty        = w_duty_reg;
    assign weapon_level       = level_reg;
    assign right_waiting      = (right_start_reg != 32'd0);
    assign left_waiting       = (left_start_reg != 32'd0);

endmodule

// File: rtl/hbrd_checker.sv
// port-level checks for the h-bridge reversal core and the bind that attaches them
module hbrd_checker
    import hbrd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] right_forward_duty,
    input logic [7:0] right_reverse_duty,
    input logic [7:0] left_forward_duty,
    input logic [7:0] left_reverse_duty,
    input logic [7:0] weapon_duty,
    input logic [3:0] weapon_level
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(right_forward_duty)
            && $stable(left_forward_duty) && $stable(weapon_level))
        else $error("stalled result changed");

    // input only stalls when the result register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while output free");

    // both halves of a side never driven together
    a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_forward_duty == 8'd0 || right_reverse_duty == 8'd0)
            && (left_forward_duty == 8'd0 || left_reverse_duty == 8'd0))
        else $error("both halves of a side driven");

    // weapon duty follows the level
    a_weapon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weapon_level <= LEVEL_MAX
            && weapon_duty == weapon_duty_of(weapon_level))
        else $error("weapon duty does not match level");

endmodule

bind dual_hbridge_reversal_delay_core hbrd_checker u_hbrd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .right_forward_duty (right_forward_duty),
    .right_reverse_duty (right_reverse_duty),
    .left_forward_duty  (left_forward_duty),
    .left_reverse_duty  (left_reverse_duty),
    .weapon_duty        (weapon_duty),
    .weapon_level       (weapon_level)
);

// File: tb/dual_hbridge_reversal_delay_core_tb.sv
// testbench for the dual h-bridge reversal delay core: random and directed commands, scoreboard
module dual_hbridge_reversal_delay_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hbrd_pkg::*;

    typedef struct packed {
        logic [7:0] rf;
        logic [7:0] rr;
        logic [7:0] lf;
        logic [7:0] lr;
        logic [7:0] wpn;
        logic [3:0] level;
        logic       rwait;
        logic       lwait;
    } duty_report_t;

    // tracks bridge, delay and weapon state and holds the duties each command should produce
    class hbridge_checker;
        int           deadband;
        logic [31:0]  delay_ms;
        bit           dir_fwd[2];
        logic [31:0]  start_ms[2];
        logic [3:0]   level;
        logic [7:0]   duty[5];
        duty_report_t pending_duties[$];
        int           errors;
        int           checked;
        int           delays_started;
        int           delays_expired;
        int           drive_writes;

        function new();
            deadband = DEADBAND_RESET;
            delay_ms = DELAY_RESET;
            dir_fwd  = '{0, 0};
            start_ms = '{0, 0};
            level    = 0;
            duty     = '{0, 0, 0, 0, 0};
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            if (idx == REG_STICK_DEADBAND)
                deadband = value[6:0];
            else
                delay_ms = value[15:0];
        endfunction

        function logic [7:0] doubled(int mag);
            int v;
            v = mag * 2;
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function logic [7:0] weapon_duty_for(logic [3:0] lvl);
            return (lvl == 0) ? 8'd0 : 8'(255 / (11 - int'(lvl)));
        endfunction

        function void apply_drive(int side, int dc, logic [31:0] now);
            int          fi;
            int          ri;
            bit          want_fwd;
            logic [31:0] expiry;
            fi = 2 * side;
            ri = fi + 1;
            if (dc < -deadband)
            begin
                want_fwd = 0;
                duty[fi] = 0;
            end
            else if (dc > deadband)
            begin
                want_fwd = 1;
                duty[ri] = 0;
            end
            else
            begin
                duty[fi] = 0;
                duty[ri] = 0;
                return;
            end
            // wraps at 32 bits
            expiry = start_ms[side] + delay_ms;
            if (dir_fwd[side] != want_fwd)
            begin
                start_ms[side] = now;
                dir_fwd[side]  = want_fwd;
                if (now != 0)
                    delays_started++;
            end
            else if (start_ms[side] != 0)
            begin
                if (now > expiry)
                begin
                    start_ms[side] = 0;
                    delays_expired++;
                end
            end
            else
            begin
                drive_writes++;
                if (want_fwd)
                    duty[fi] = doubled(dc);
                else
                    duty[ri] = doubled(-dc);
            end
        endfunction

        function void note_command(action_t act, logic signed [7:0] stick, logic [31:0] now);
            duty_report_t want;
            case (act)
                ACT_DRIVE_RIGHT: apply_drive(0, int'(stick), now);
                ACT_DRIVE_LEFT:  apply_drive(1, int'(stick), now);
                ACT_WEAPON_UP:
                begin
                    if (level < LEVEL_MAX)
                        level++;
                    duty[4] = weapon_duty_for(level);
                end
                default:
                begin
                    if (level > 0)
                        level--;
                    duty[4] = weapon_duty_for(level);
                end
            endcase
            want.rf    = duty[0];
            want.rr    = duty[1];
            want.lf    = duty[2];
            want.lr    = duty[3];
            want.wpn   = duty[4];
            want.level = level;
            want.rwait = (start_ms[0] != 0);
            want.lwait = (start_ms[1] != 0);
            pending_duties.push_back(want);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_duties(duty_report_t got);
            duty_report_t want;
            if (pending_duties.size() == 0)
            begin
                errors++;
                $display("%0t: result with no command pending, expected none got %h", $time, got);
                return;
            end
            want = pending_duties.pop_front();
            checked++;
            compare_field("right_forward_duty", want.rf, got.rf);
            compare_field("right_reverse_duty", want.rr, got.rr);
            compare_field("left_forward_duty", want.lf, got.lf);
            compare_field("left_reverse_duty", want.lr, got.lr);
            compare_field("weapon_duty", want.wpn, got.wpn);
            compare_field("weapon_level", 8'(want.level), 8'(got.level));
            compare_field("right_waiting", 8'(want.rwait), 8'(got.rwait));
            compare_field("left_waiting", 8'(want.lwait), 8'(got.lwait));
        endfunction

        function int pending();
            return pending_duties.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic signed [7:0] stick_value;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  right_forward_duty;
    logic [7:0]  right_reverse_duty;
    logic [7:0]  left_forward_duty;
    logic [7:0]  left_reverse_duty;
    logic [7:0]  weapon_duty;
    logic [3:0]  weapon_level;
    logic        right_waiting;
    logic        left_waiting;

    hbridge_checker sb;
    int          rx_hold;
    int          no_gap_left;
    int          stall_cycles;
    int          commands_sent;
    int          settings_used;
    bit          want_neg[2];
    logic [31:0] clock_ms;

    dual_hbridge_reversal_delay_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .stick_value        (stick_value),
        .now_ms             (now_ms),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .right_forward_duty (right_forward_duty),
        .right_reverse_duty (right_reverse_duty),
        .left_forward_duty  (left_forward_duty),
        .left_reverse_duty  (left_reverse_duty),
        .weapon_duty        (weapon_duty),
        .weapon_level       (weapon_level),
        .right_waiting      (right_waiting),
        .left_waiting       (left_waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function int pick_gap();
        int r;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_command(action_t act, logic signed [7:0] stick, logic [31:0] now);
        int gap;
        in_valid    <= 1'b1;
        action      <= act;
        stick_value <= stick;
        now_ms      <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_command(act, stick, now);
        commands_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // two-stage pipeline, plus spare margin
        repeat (6) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic configure(int db, int dly);
        drain();
        write_register(REG_STICK_DEADBAND, db);
        write_register(REG_REVERSAL_DELAY_MS, dly);
        settings_used++;
    endtask

    task automatic run_directed();
        int k;
        send_command(ACT_DRIVE_RIGHT, 0, 32'd50);
        // direction change at time zero never waits
        send_command(ACT_DRIVE_RIGHT, 127, 32'd0);
        send_command(ACT_DRIVE_RIGHT, 127, 32'd1);
        send_command(ACT_DRIVE_RIGHT, -128, 32'd100);
        // exactly at start + delay is still waiting
        send_command(ACT_DRIVE_RIGHT, -128, 32'd600);
        send_command(ACT_DRIVE_RIGHT, -128, 32'd601);
        send_command(ACT_DRIVE_RIGHT, -128, 32'd602);
        send_command(ACT_DRIVE_LEFT, -50, 32'd5);
        send_command(ACT_DRIVE_LEFT, 11, 32'd10);
        send_command(ACT_DRIVE_LEFT, 10, 32'd11);
        send_command(ACT_DRIVE_LEFT, -11, 32'd20);
        // expiry sum wraps past 32 bits
        send_command(ACT_DRIVE_LEFT, 50, 32'hFFFF_FF00);
        send_command(ACT_DRIVE_LEFT, 50, 32'hFFFF_FFFF);
        send_command(ACT_DRIVE_LEFT, 50, 32'd0);
        send_command(ACT_WEAPON_DOWN, 0, 32'd0);
        for (k = 0; k < 10; k++)
            send_command(ACT_WEAPON_UP, 8'(k * 37), 32'(k));
        send_command(ACT_WEAPON_DOWN, -1, 32'hFFFF_FFFF);
    endtask

    task automatic random_commands(int count);
        int          k;
        int          r;
        int          side;
        int          sv;
        int          step_max;
        action_t     act;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                act = ACT_DRIVE_RIGHT;
            else if (r < 80)
                act = ACT_DRIVE_LEFT;
            else if (r < 90)
                act = ACT_WEAPON_UP;
            else
                act = ACT_WEAPON_DOWN;
            side = (act == ACT_DRIVE_LEFT) ? 1 : 0;
            // keep a preferred direction per side so delays get a chance to run out
            if ($urandom_range(0, 99) < 12)
                want_neg[side] = !want_neg[side];
            r = $urandom_range(0, 99);
            if (r < 70)
                sv = want_neg[side] ? -int'($urandom_range(0, 128)) : int'($urandom_range(0, 127));
            else if (r < 85)
            begin
                sv = sb.deadband + int'($urandom_range(0, 1));
                if (want_neg[side])
                    sv = -sv;
                else if (sv > 127)
                    sv = 127;
            end
            else if (r < 93)
                sv = want_neg[side] ? -128 : 127;
            else
                sv = $urandom_range(0, 255);
            step_max = sb.delay_ms / 3 + 8;
            r = $urandom_range(0, 99);
            if (r >= 84 && r < 92 && sb.start_ms[side] != 0)
                clock_ms = sb.start_ms[side] + sb.delay_ms + $urandom_range(0, 1);
            else if (r < 92)
                clock_ms = clock_ms + $urandom_range(0, step_max);
            else if (r < 97)
                clock_ms = $urandom;
            else if (r < 98)
                clock_ms = 32'd0;
            else
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
            if ($urandom_range(0, 99) == 0)
                no_gap_left = $urandom_range(20, 40);
            send_command(act, sv[7:0], clock_ms);
        end
    endtask

    // result side: checks accepted results and stalls at random
    initial
    begin
        int run;
        int r;
        bit stall_mode;
        duty_report_t got;
        out_stall  <= 1'b0;
        run        = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && in_valid && in_stall)
                stall_cycles++;
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{right_forward_duty, right_reverse_duty, left_forward_duty,
                        left_reverse_duty, weapon_duty, weapon_level,
                        right_waiting, left_waiting};
                sb.check_duties(got);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run == 0)
                begin
                    r = $urandom_range(0, 99);
                    stall_mode = (r >= 45 && r < 98);
                    if (r < 42)
                        run = $urandom_range(1, 20);
                    else if (r < 45)
                        run = $urandom_range(50, 100);
                    else if (r < 85)
                        run = $urandom_range(1, 3);
                    else if (r < 97)
                        run = $urandom_range(4, 12);
                    else
                        run = $urandom_range(20, 50);
                end
                run--;
                out_stall <= stall_mode;
            end
        end
    end

    initial
    begin
        sb            = new();
        rx_hold       = 0;
        no_gap_left   = 0;
        stall_cycles  = 0;
        commands_sent = 0;
        settings_used = 1;
        want_neg      = '{0, 0};
        clock_ms      = 32'd1000;
        rst_n         = 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        action        <= ACT_DRIVE_RIGHT;
        stick_value   <= '0;
        now_ms        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        random_commands(255);

        configure(0, 0);
        random_commands(255);

        configure(127, 65535);
        random_commands(120);
        // sender waits for every outstanding result mid-phase
        drain();
        random_commands(135);

        configure($urandom_range(1, 126), $urandom_range(1, 3000));
        random_commands(100);
        // hold results back while requests keep coming, so the input stalls
        rx_hold     = 150;
        no_gap_left = 40;
        random_commands(155);

        configure(3, 1);
        random_commands(255);

        drain();
        repeat (10) @(posedge clk);
        $display("ran %0d commands over %0d register settings, %0d results checked",
                 commands_sent, settings_used, sb.checked);
        $display("%0d reversal delays started, %0d ran out, %0d drive writes, %0d input stall cycles",
                 sb.delays_started, sb.delays_expired, sb.drive_writes, stall_cycles);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/hbrd_pkg.sv
rtl/dual_hbridge_reversal_delay_core.sv
rtl/hbrd_checker.sv
tb/dual_hbridge_reversal_delay_core_tb.sv
